// ----- rtl/eucr_pkg.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm generator package
// Shared widths, group record, sequencer states and mask helper.
// ----------------------------------------------------------------------------
package eucr_pkg;

    // Field widths of the request and result transactions
    localparam int STEP_W      = 7;
    localparam int PAT_W       = 64;
    localparam int LEN_W       = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;

    // Default largest step count
    localparam int MAX_STEPS_DEF = 64;

    // One group of the distribution: its bits and its length in slots
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } t_grp;

    localparam int GRP_W = $bits(t_grp);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_OUTER,
        ST_INNER,
        ST_JOIN_RD,
        ST_JOIN_WR,
        ST_READ,
        ST_DONE
    } t_state;

    // Mask of n ones from bit 0, saturating at the full word
    function automatic logic [PAT_W-1:0] ones_mask(input logic [LEN_W-1:0] n);
        logic [PAT_W-1:0] m;
        if (n >= LEN_W'(PAT_W)) begin
            m = '1;
        end else begin
            m = (PAT_W'(1) << n) - PAT_W'(1);
        end
        return m;
    endfunction

endpackage

// ----- rtl/euclidean_rhythm_generator.sv -----
// Flow: accept the request, write the initial groups (pulse units plus empty slots),
//   join groups in pairing passes and rounds, read the groups out and load the result.
// Throughput: one request at a time; the group store and its single join
//   datapath hold only one request. A waiting result does not block the next request.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Euclidean rhythm generator
// Builds the grouped Bjorklund rhythm for a step, pulse and burst request by
// repeated front/back group joins in a group store, then reads it out.
// ----------------------------------------------------------------------------
module euclidean_rhythm_generator #(
    parameter int MAX_STEPS = eucr_pkg::MAX_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request: steps [6:0], pulses [13:7], burst_len [20:14]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [eucr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result: pattern [63:0], length [70:64]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [eucr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int SW = eucr_pkg::STEP_W;
    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    eucr_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_steps, n_steps;
    logic [SW-1:0] r_burst, n_burst;
    logic [SW-1:0] r_rem,   n_rem;
    logic [SW-1:0] r_zleft, n_zleft;
    logic [SW-1:0] r_f,     n_f;
    logic [SW-1:0] r_b,     n_b;
    logic [SW-1:0] r_back,  n_back;
    logic [SW-1:0] r_idx,   n_idx;
    logic [SW-1:0] r_cnt,   n_cnt;
    logic [SW-1:0] r_pos,   n_pos;
    logic          r_last,  n_last;
    logic          r_rd_vld, n_rd_vld;
    logic [eucr_pkg::PAT_W-1:0] r_pat, n_pat;

    logic                       r_out_vld, n_out_vld;
    logic [eucr_pkg::PAT_W-1:0] r_out_pat, n_out_pat;
    logic [SW-1:0]              r_out_len, n_out_len;

    logic [SW-1:0] w_in_steps, w_in_pulses, w_in_burst;
    logic [SW-1:0] w_steps_c, w_pulses_c, w_burst_c, w_ulen, w_sum, w_src;
    logic          w_accept, w_issue, w_load;

    logic                       w_we;
    logic [AW-1:0]              w_waddr, w_raddr_a, w_raddr_b;
    eucr_pkg::t_grp             w_wgrp, w_ra, w_rb;
    logic [eucr_pkg::GRP_W-1:0] w_rdata_a, w_rdata_b;

    // Group store
    eucr_ram #(
        .WIDTH (eucr_pkg::GRP_W),
        .DEPTH (MAX_STEPS)
    ) u_grp_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wgrp),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_ra = w_rdata_a;
    assign w_rb = w_rdata_b;

    // Unpack and normalise the request
    assign w_in_steps  = s_axis_tdata[SW-1:0];
    assign w_in_pulses = s_axis_tdata[2*SW-1:SW];
    assign w_in_burst  = s_axis_tdata[3*SW-1:2*SW];
    assign w_steps_c   = (w_in_steps > SW'(MAX_STEPS)) ? SW'(MAX_STEPS) : w_in_steps;
    assign w_pulses_c  = (w_in_pulses > w_steps_c) ? w_steps_c : w_in_pulses;
    assign w_burst_c   = (w_in_burst == '0) ? SW'(1) : w_in_burst;

    assign s_axis_tready = (r_state == eucr_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Unit length during the fill sweep, join length, back address, read-out issue
    assign w_ulen  = (r_burst < r_rem) ? r_burst : r_rem;
    assign w_sum   = w_ra.len + w_rb.len;
    assign w_src   = r_back + r_idx;
    assign w_issue = (r_idx < r_cnt);
    assign w_load  = (r_state == eucr_pkg::ST_DONE) && (!r_out_vld || m_axis_tready);

    // Sequencer: next state, datapath and store control
    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_burst   = r_burst;
        n_rem     = r_rem;
        n_zleft   = r_zleft;
        n_f       = r_f;
        n_b       = r_b;
        n_back    = r_back;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_last    = r_last;
        n_rd_vld  = 1'b0;
        n_pat     = r_pat;
        w_we      = 1'b0;
        w_waddr   = r_idx[AW-1:0];
        w_wgrp    = '0;
        w_raddr_a = r_idx[AW-1:0];
        w_raddr_b = w_src[AW-1:0];

        unique case (r_state)
            eucr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_steps = w_steps_c;
                    n_burst = w_burst_c;
                    n_rem   = w_pulses_c;
                    n_zleft = w_steps_c - w_pulses_c;
                    n_b     = w_steps_c - w_pulses_c;
                    n_f     = '0;
                    n_idx   = '0;
                    n_pat   = '0;
                    if (w_steps_c == '0 || w_pulses_c == '0) begin
                        n_state = eucr_pkg::ST_DONE;
                    end else begin
                        n_state = eucr_pkg::ST_INIT;
                    end
                end
            end

            eucr_pkg::ST_INIT: begin
                // Write pulse units first, then single empty slots
                w_we = 1'b1;
                if (r_rem != '0) begin
                    w_wgrp.len  = w_ulen;
                    w_wgrp.bits = eucr_pkg::ones_mask(w_ulen);
                    n_rem       = r_rem - w_ulen;
                    n_f         = r_f + SW'(1);
                end else begin
                    w_wgrp.len  = SW'(1);
                    w_wgrp.bits = '0;
                    n_zleft     = r_zleft - SW'(1);
                end
                n_idx = r_idx + SW'(1);
                if (n_rem == '0 && n_zleft == '0) begin
                    n_state = eucr_pkg::ST_OUTER;
                end
            end

            eucr_pkg::ST_OUTER: begin
                if (r_b > SW'(1)) begin
                    n_back  = r_f;
                    n_state = eucr_pkg::ST_INNER;
                end else begin
                    n_cnt   = r_f + r_b;
                    n_idx   = '0;
                    n_pos   = '0;
                    n_state = eucr_pkg::ST_READ;
                end
            end

            eucr_pkg::ST_INNER: begin
                // Pair fronts with backs; surplus backs wait for the next pass, leftover fronts become backs
                if (r_b > r_f) begin
                    n_b    = r_b - r_f;
                    n_cnt  = r_f;
                    n_last = 1'b0;
                end else begin
                    n_f    = r_b;
                    n_b    = r_f - r_b;
                    n_cnt  = r_b;
                    n_last = 1'b1;
                end
                n_idx   = '0;
                n_state = eucr_pkg::ST_JOIN_RD;
            end

            eucr_pkg::ST_JOIN_RD: begin
                n_state = eucr_pkg::ST_JOIN_WR;
            end

            eucr_pkg::ST_JOIN_WR: begin
                // Append the back group to the tail of the front group
                w_we        = 1'b1;
                w_wgrp.len  = w_sum;
                w_wgrp.bits = w_ra.bits;
                if (w_ra.len < SW'(eucr_pkg::PAT_W)) begin
                    w_wgrp.bits = w_ra.bits | (w_rb.bits << w_ra.len);
                end
                n_idx = r_idx + SW'(1);
                if (n_idx == r_cnt) begin
                    if (r_last) begin
                        n_state = eucr_pkg::ST_OUTER;
                    end else begin
                        n_back  = r_back + r_cnt;
                        n_state = eucr_pkg::ST_INNER;
                    end
                end else begin
                    n_state = eucr_pkg::ST_JOIN_RD;
                end
            end

            eucr_pkg::ST_READ: begin
                // Issue one read a cycle and place each group after the last
                n_rd_vld = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + SW'(1);
                end
                if (r_rd_vld) begin
                    if (r_pos < SW'(eucr_pkg::PAT_W)) begin
                        n_pat = r_pat | (w_ra.bits << r_pos);
                    end
                    n_pos = r_pos + w_ra.len;
                end
                if (!w_issue && !r_rd_vld) begin
                    n_state = eucr_pkg::ST_DONE;
                end
            end

            eucr_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = eucr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = eucr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once taken
    always_comb begin
        n_out_vld = w_load || (r_out_vld && !m_axis_tready);
        n_out_pat = r_out_pat;
        n_out_len = r_out_len;
        if (w_load) begin
            n_out_pat = r_pat & eucr_pkg::ones_mask(r_steps);
            n_out_len = r_steps;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= eucr_pkg::ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_steps   <= n_steps;
        r_burst   <= n_burst;
        r_rem     <= n_rem;
        r_zleft   <= n_zleft;
        r_f       <= n_f;
        r_b       <= n_b;
        r_back    <= n_back;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_pos     <= n_pos;
        r_last    <= n_last;
        r_pat     <= n_pat;
        r_out_pat <= n_out_pat;
        r_out_len <= n_out_len;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_len, r_out_pat};

`ifndef SYNTHESIS
    // A joined group never outgrows the rhythm
    a_join_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eucr_pkg::ST_JOIN_WR) |->
        (({1'b0, w_ra.len} + {1'b0, w_rb.len}) <= {1'b0, r_steps}))
        else $error("joined group longer than steps");

    // Back groups stay inside the store
    a_src_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eucr_pkg::ST_JOIN_RD) |->
        (({1'b0, r_back} + {1'b0, r_idx}) < (SW + 1)'(MAX_STEPS)))
        else $error("back group address out of range");

    // A pairing pass always has fronts and at least one back
    a_pair_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eucr_pkg::ST_INNER) |-> (r_f != '0 && r_b != '0))
        else $error("pairing round without fronts");

    // Read-out covers exactly the step count
    a_read_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eucr_pkg::ST_READ && !w_issue && !r_rd_vld) |->
        (r_pos == r_steps))
        else $error("groups do not cover the steps");
`endif

endmodule

// ----- rtl/eucr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module eucr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
